// File: design/cda_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes, calendar tables and width helpers for the calendar
// date arithmetic block. Depends on nothing; the top level and cda_seq use it.
package cda_pkg;

   // Field widths of the request and response words
   localparam int ACT_W   = 2;
   localparam int YEAR_W  = 12;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int COUNT_W = 16;
   localparam int DIFF_W  = 21;
   localparam int STAT_W  = 2;

   // Calendar constants
   localparam int MAX_YEAR_DEFAULT  = 4095;
   localparam int IN_YEAR_MAX       = 4095;
   localparam int YEAR_SHIFT        = 400;
   localparam int ERA_YEARS         = 400;
   localparam int DAYS_PER_ERA      = 146097;
   localparam int DAYS_PER_YEAR     = 365;
   localparam int YEARS_PER_CENTURY = 100;
   localparam int MONTHS            = 12;
   localparam int FEBRUARY          = 2;
   localparam int SPAN_MARGIN       = 600;
   localparam int RECIP_GUARD       = 7;
   localparam int DIFF_MAX          = 2097151;

   // Date after reset
   localparam int HELD_YEAR_RESET  = 1900;
   localparam int HELD_MONTH_RESET = 1;
   localparam int HELD_DAY_RESET   = 1;

   typedef enum logic [ACT_W-1:0] {
      ACT_LOAD = 2'd0,
      ACT_ADD  = 2'd1,
      ACT_SUB  = 2'd2,
      ACT_CMP  = 2'd3
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      action_type         action;
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [COUNT_W-1:0] count;
   } cmd_type;

   typedef struct packed {
      logic              gt;
      logic              eq;
      logic [DIFF_W-1:0] diff;
      status_type        status;
   } result_type;

   // Days in a month of a common year; zero for a code that is no month
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] n;
      case (m)
         4'd1:    n = 5'd31;
         4'd2:    n = 5'd28;
         4'd3:    n = 5'd31;
         4'd4:    n = 5'd30;
         4'd5:    n = 5'd31;
         4'd6:    n = 5'd30;
         4'd7:    n = 5'd31;
         4'd8:    n = 5'd31;
         4'd9:    n = 5'd30;
         4'd10:   n = 5'd31;
         4'd11:   n = 5'd30;
         4'd12:   n = 5'd31;
         default: n = 5'd0;
      endcase
      return n;
   endfunction

   // Month index in a year that starts in March
   function automatic logic [MONTH_W-1:0] month_to_mp(input logic [MONTH_W-1:0] m);
      logic [MONTH_W-1:0] mp;
      case (m)
         4'd1:    mp = 4'd10;
         4'd2:    mp = 4'd11;
         4'd3:    mp = 4'd0;
         4'd4:    mp = 4'd1;
         4'd5:    mp = 4'd2;
         4'd6:    mp = 4'd3;
         4'd7:    mp = 4'd4;
         4'd8:    mp = 4'd5;
         4'd9:    mp = 4'd6;
         4'd10:   mp = 4'd7;
         4'd11:   mp = 4'd8;
         4'd12:   mp = 4'd9;
         default: mp = 4'd0;
      endcase
      return mp;
   endfunction

   // Days from March 1 to the first of a March-based month
   function automatic logic [8:0] mp_offset(input logic [MONTH_W-1:0] mp);
      logic [8:0] o;
      case (mp)
         4'd0:    o = 9'd0;
         4'd1:    o = 9'd31;
         4'd2:    o = 9'd61;
         4'd3:    o = 9'd92;
         4'd4:    o = 9'd122;
         4'd5:    o = 9'd153;
         4'd6:    o = 9'd184;
         4'd7:    o = 9'd214;
         4'd8:    o = 9'd245;
         4'd9:    o = 9'd275;
         4'd10:   o = 9'd306;
         4'd11:   o = 9'd337;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

   // Widest year the datapath ever sees, shifted years included
   function automatic int year_span(input int max_year);
      return ((max_year > IN_YEAR_MAX) ? max_year : IN_YEAR_MAX) + SPAN_MARGIN;
   endfunction

   // Width of the held year
   function automatic int yw_of(input int max_year);
      return ($clog2(max_year + 1) > YEAR_W) ? $clog2(max_year + 1) : YEAR_W;
   endfunction

   // Width of a shifted year
   function automatic int syw_of(input int max_year);
      return $clog2(year_span(max_year) + 1);
   endfunction

   // Width of a day number
   function automatic int zw_of(input int max_year);
      return $clog2((DAYS_PER_YEAR + 1) * (year_span(max_year) + 2));
   endfunction

   // Exact reciprocal of one hundred for years below 2**syw
   function automatic longint m100_of(input int syw);
      return ((longint'(1) << (syw + RECIP_GUARD)) + YEARS_PER_CENTURY - 1)
             / YEARS_PER_CENTURY;
   endfunction

   // Rounded-down reciprocal of the mean year length, scaled by 2**zw
   function automatic longint mest_of(input int zw);
      return (longint'(ERA_YEARS) << zw) / DAYS_PER_ERA;
   endfunction

   // Width of the multiplier's constant operand
   function automatic int bw_of(input int max_year);
      int a;
      int b;
      a = $clog2(m100_of(syw_of(max_year)) + 1);
      b = $clog2(mest_of(zw_of(max_year)) + 1);
      a = (b > a) ? b : a;
      return (a > 9) ? a : 9;
   endfunction

endpackage

// File: design/calendar_date_arithmetic.sv
`timescale 1ns / 1ps
// Calendar date arithmetic block: top level with the response register.
// Depends on cda_pkg, cda_seq and cda_mul_unit.
//
// Usage:
//   Holds one Gregorian date; each request word carries one command (load,
//   add days, subtract days, compare) and returns exactly one response word
//   with the held date after the command, the compare flags, the day
//   difference and a status. Both channels use valid/ready.
//   A request is taken only while the sequencer is free; one command runs
//   at a time. Each day-number step uses the shared multiply-add unit
//   twice, and add/subtract then search the result year one year at a
//   time after a reciprocal estimate. A subtract that runs off the start
//   of the day count ends early with a range status.
//   The next request is taken the cycle after a response is loaded.
//   The response sits in an output register; the next request is taken
//   while it waits, and a finished command holds until that register frees.
//   Reset sets the held date to 1 January 1900 and empties the response.
module calendar_date_arithmetic #(
   parameter int MAX_YEAR = cda_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [cda_pkg::ACT_W-1:0]     req_action,
   input  logic [cda_pkg::YEAR_W-1:0]    req_in_year,
   input  logic [cda_pkg::MONTH_W-1:0]   req_in_month,
   input  logic [cda_pkg::DAY_W-1:0]     req_in_day,
   input  logic [cda_pkg::COUNT_W-1:0]   req_day_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cda_pkg::YEAR_W-1:0]    rsp_out_year,
   output logic [cda_pkg::MONTH_W-1:0]   rsp_out_month,
   output logic [cda_pkg::DAY_W-1:0]     rsp_out_day,
   output logic                          rsp_is_greater,
   output logic                          rsp_is_equal,
   output logic [cda_pkg::DIFF_W-1:0]    rsp_difference,
   output logic [cda_pkg::STAT_W-1:0]    rsp_status
);

   localparam int AW = cda_pkg::zw_of(MAX_YEAR);
   localparam int BW = cda_pkg::bw_of(MAX_YEAR);

   cda_pkg::cmd_type              cmd;
   cda_pkg::result_type           result;
   logic                          seq_done;
   logic                          out_free;
   logic [cda_pkg::YEAR_W-1:0]    date_year;
   logic [cda_pkg::MONTH_W-1:0]   date_month;
   logic [cda_pkg::DAY_W-1:0]     date_day;
   logic [AW-1:0]                 mul_a;
   logic [BW-1:0]                 mul_b;
   logic [AW-1:0]                 mul_c;
   logic [AW+BW-1:0]              mul_p;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [cda_pkg::YEAR_W-1:0]    year_ff, year_in;
   logic [cda_pkg::MONTH_W-1:0]   month_ff, month_in;
   logic [cda_pkg::DAY_W-1:0]     day_ff, day_in;
   cda_pkg::result_type           res_ff, res_in;

   // Pack the request word
   assign cmd.action = cda_pkg::action_type'(req_action);
   assign cmd.year   = req_in_year;
   assign cmd.month  = req_in_month;
   assign cmd.day    = req_in_day;
   assign cmd.count  = req_day_count;

   cda_seq #(
      .MAX_YEAR (MAX_YEAR),
      .AW       (AW),
      .BW       (BW)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (req_valid),
      .cmd_ready  (req_ready),
      .cmd        (cmd),
      .done       (seq_done),
      .out_free   (out_free),
      .date_year  (date_year),
      .date_month (date_month),
      .date_day   (date_day),
      .result     (result),
      .mul_a      (mul_a),
      .mul_b      (mul_b),
      .mul_c      (mul_c),
      .mul_p      (mul_p)
   );

   cda_mul_unit #(
      .AW (AW),
      .BW (BW)
   ) u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_c (mul_c),
      .mul_p (mul_p)
   );

   // Load the response register when it is empty or being drained
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      year_in      = year_ff;
      month_in     = month_ff;
      day_in       = day_ff;
      res_in       = res_ff;
      if (seq_done && out_free) begin
         rsp_valid_in = 1'b1;
         year_in      = date_year;
         month_in     = date_month;
         day_in       = date_day;
         res_in       = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      res_ff   <= res_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_year   = year_ff;
   assign rsp_out_month  = month_ff;
   assign rsp_out_day    = day_ff;
   assign rsp_is_greater = res_ff.gt;
   assign rsp_is_equal   = res_ff.eq;
   assign rsp_difference = res_ff.diff;
   assign rsp_status     = res_ff.status;

   // A finished command lands in the response register
   a_done_lands: assert property (@(posedge clock) disable iff (reset)
      (seq_done && out_free) |=> rsp_valid)
      else $error("finished command did not reach the response register");

   // A request just taken never finishes in the next cycle
   a_no_instant_done: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !seq_done)
      else $error("command finished without running the sequencer");

   // An equal compare gives no distance, no greater flag and a clean status
   a_equal_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_equal) |->
         (rsp_difference == '0) && !rsp_is_greater && (rsp_status == cda_pkg::ST_OK))
      else $error("equal compare with inconsistent fields");

   // The held month is always a real month
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_out_month >= 4'd1) && (rsp_out_month <= 4'd12)))
      else $error("response month out of range");

endmodule

// File: design/cda_mul_unit.sv
`timescale 1ns / 1ps
// Shared multiply-add unit of the date block: one registered a * b + c.
// Depends on nothing beyond its parameters; driven by cda_seq.
module cda_mul_unit #(
   parameter int AW = 21,
   parameter int BW = 14
) (
   input  logic               clock,
   input  logic [AW-1:0]      mul_a,
   input  logic [BW-1:0]      mul_b,
   input  logic [AW-1:0]      mul_c,
   output logic [AW+BW-1:0]   mul_p
);

   localparam int PW = AW + BW;

   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;

   // Form the product and add the offset term
   always_comb begin
      prod_in = PW'(mul_a) * PW'(mul_b) + PW'(mul_c);
   end

   // Hold the result for the sequencer's next step
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_p = prod_ff;

endmodule

// File: design/cda_seq.sv
`timescale 1ns / 1ps
// Sequencer and date datapath: holds the date, runs each command through the
// shared multiply-add unit. Depends on cda_pkg; drives cda_mul_unit.
module cda_seq #(
   parameter int MAX_YEAR = cda_pkg::MAX_YEAR_DEFAULT,
   parameter int AW       = cda_pkg::zw_of(cda_pkg::MAX_YEAR_DEFAULT),
   parameter int BW       = cda_pkg::bw_of(cda_pkg::MAX_YEAR_DEFAULT)
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  cda_pkg::cmd_type              cmd,
   output logic                          done,
   input  logic                          out_free,
   output logic [cda_pkg::YEAR_W-1:0]    date_year,
   output logic [cda_pkg::MONTH_W-1:0]   date_month,
   output logic [cda_pkg::DAY_W-1:0]     date_day,
   output cda_pkg::result_type           result,
   output logic [AW-1:0]                 mul_a,
   output logic [BW-1:0]                 mul_b,
   output logic [AW-1:0]                 mul_c,
   input  logic [AW+BW-1:0]              mul_p
);

   localparam int YW   = cda_pkg::yw_of(MAX_YEAR);
   localparam int SYW  = cda_pkg::syw_of(MAX_YEAR);
   localparam int ZW   = AW;
   localparam int S100 = SYW + cda_pkg::RECIP_GUARD;
   localparam logic [63:0] M100 = 64'(cda_pkg::m100_of(SYW));
   localparam logic [63:0] MEST = 64'(cda_pkg::mest_of(ZW));

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_VQ   = 10'b0000000010,
      ST_VCHK = 10'b0000000100,
      ST_YQ   = 10'b0000001000,
      ST_YF   = 10'b0000010000,
      ST_YR   = 10'b0000100000,
      ST_EST  = 10'b0001000000,
      ST_ERD  = 10'b0010000000,
      ST_CONV = 10'b0100000000,
      ST_DONE = 10'b1000000000
   } state_type;

   state_type                     state_ff, state_in;
   cda_pkg::action_type           act_ff, act_in;
   logic [cda_pkg::YEAR_W-1:0]    iy_ff, iy_in;
   logic [cda_pkg::MONTH_W-1:0]   im_ff, im_in;
   logic [cda_pkg::DAY_W-1:0]     id_ff, id_in;
   logic [cda_pkg::COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [YW-1:0]                 held_year_ff, held_year_in;
   logic [cda_pkg::MONTH_W-1:0]   held_month_ff, held_month_in;
   logic [cda_pkg::DAY_W-1:0]     held_day_ff, held_day_in;
   logic [SYW-1:0]                c_ff, c_in;
   logic                          from_input_ff, from_input_in;
   logic                          search_ff, search_in;
   logic [ZW-1:0]                 a_ff, a_in;
   logic [ZW-1:0]                 z_ff, z_in;
   logic [ZW-1:0]                 fe_ff, fe_in;
   logic                          gt_ff, gt_in;
   logic                          eq_ff, eq_in;
   logic [cda_pkg::DIFF_W-1:0]    diff_ff, diff_in;
   cda_pkg::status_type           status_ff, status_in;

   // Datapath helpers
   logic [SYW-1:0]                q_w;
   logic [ZW-1:0]                 f_w;
   logic [SYW-1:0]                ys_held;
   logic [SYW-1:0]                ys_input;
   logic [cda_pkg::MONTH_W-1:0]   sel_month;
   logic [cda_pkg::DAY_W-1:0]     sel_day;
   logic [ZW-1:0]                 addend;
   logic [SYW-1:0]                iy_ext;
   logic [SYW-1:0]                hund;
   logic                          leap_in;
   logic [cda_pkg::DAY_W-1:0]     dim;
   logic                          in_ok;
   logic                          held_gt;
   logic                          held_eq;
   logic [ZW:0]                   z_add;
   logic [ZW:0]                   z_sub;
   logic [ZW-1:0]                 abs_d;
   logic [8:0]                    doy;
   logic [cda_pkg::MONTH_W-1:0]   mp_found;
   logic [cda_pkg::MONTH_W-1:0]   conv_month;
   logic [cda_pkg::DAY_W-1:0]     conv_day;
   logic [SYW-1:0]                ys_new;
   logic [SYW-1:0]                yr_new;
   logic                          year_ok;

   // Slice the multiplier result: quotient by one hundred, or a day number
   assign q_w = mul_p[S100 +: SYW];
   assign f_w = mul_p[ZW-1:0];

   // Shifted years, one less for January and February
   assign ys_held  = SYW'(held_year_ff) + SYW'(cda_pkg::YEAR_SHIFT)
                   - SYW'(held_month_ff <= 4'(cda_pkg::FEBRUARY));
   assign ys_input = SYW'(iy_ff) + SYW'(cda_pkg::YEAR_SHIFT)
                   - SYW'(im_ff <= 4'(cda_pkg::FEBRUARY));

   // Pick the date under conversion and form the leap-day terms
   always_comb begin
      sel_month = from_input_ff ? im_ff : held_month_ff;
      sel_day   = from_input_ff ? id_ff : held_day_ff;
      addend    = ZW'(c_ff >> 2) - ZW'(q_w) + ZW'(q_w >> 2);
      if (!search_ff) begin
         addend = addend + ZW'(cda_pkg::mp_offset(cda_pkg::month_to_mp(sel_month)))
                + ZW'(sel_day) - ZW'(1);
      end
   end

   // Check the input date; leap test from the exact century quotient
   always_comb begin
      iy_ext  = SYW'(iy_ff);
      hund    = (q_w << 6) + (q_w << 5) + (q_w << 2);
      leap_in = (iy_ff[1:0] == 2'd0) && ((hund != iy_ext) || (q_w[1:0] == 2'd0));
      dim     = cda_pkg::month_len(im_ff)
              + 5'((im_ff == 4'(cda_pkg::FEBRUARY)) && leap_in);
      in_ok   = (id_ff != '0) && (id_ff <= dim);
      held_eq = (held_year_ff == YW'(iy_ff)) && (held_month_ff == im_ff)
              && (held_day_ff == id_ff);
      if (held_year_ff != YW'(iy_ff)) begin
         held_gt = held_year_ff > YW'(iy_ff);
      end else if (held_month_ff != im_ff) begin
         held_gt = held_month_ff > im_ff;
      end else begin
         held_gt = held_day_ff > id_ff;
      end
   end

   // Move the day number and measure the distance between two dates
   always_comb begin
      z_add = {1'b0, f_w} + (ZW+1)'(cnt_ff);
      z_sub = {1'b0, f_w} - (ZW+1)'(cnt_ff);
      abs_d = (a_ff > f_w) ? (a_ff - f_w) : (f_w - a_ff);
   end

   // Split the day of the year into month and day
   always_comb begin
      doy      = 9'(z_ff - fe_ff);
      mp_found = '0;
      for (int i = 0; i < cda_pkg::MONTHS; i++) begin
         if (cda_pkg::mp_offset(4'(i)) <= doy) begin
            mp_found = 4'(i);
         end
      end
      conv_day   = 5'(doy - cda_pkg::mp_offset(mp_found) + 9'd1);
      conv_month = (mp_found < 4'd10) ? (mp_found + 4'd3) : (mp_found - 4'd9);
      ys_new     = c_ff - SYW'(1) + SYW'(conv_month <= 4'(cda_pkg::FEBRUARY));
      yr_new     = ys_new - SYW'(cda_pkg::YEAR_SHIFT);
      year_ok    = (ys_new >= SYW'(cda_pkg::YEAR_SHIFT))
                && (32'(yr_new) <= 32'(MAX_YEAR));
   end

   // Sequence one command over the shared unit
   always_comb begin
      state_in      = state_ff;
      act_in        = act_ff;
      iy_in         = iy_ff;
      im_in         = im_ff;
      id_in         = id_ff;
      cnt_in        = cnt_ff;
      held_year_in  = held_year_ff;
      held_month_in = held_month_ff;
      held_day_in   = held_day_ff;
      c_in          = c_ff;
      from_input_in = from_input_ff;
      search_in     = search_ff;
      a_in          = a_ff;
      z_in          = z_ff;
      fe_in         = fe_ff;
      gt_in         = gt_ff;
      eq_in         = eq_ff;
      diff_in       = diff_ff;
      status_in     = status_ff;
      mul_a         = '0;
      mul_b         = '0;
      mul_c         = '0;
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               act_in        = cmd.action;
               iy_in         = cmd.year;
               im_in         = cmd.month;
               id_in         = cmd.day;
               cnt_in        = cmd.count;
               status_in     = cda_pkg::ST_OK;
               gt_in         = 1'b0;
               eq_in         = 1'b0;
               diff_in       = '0;
               from_input_in = 1'b0;
               search_in     = 1'b0;
               if ((cmd.action == cda_pkg::ACT_ADD) || (cmd.action == cda_pkg::ACT_SUB)) begin
                  c_in     = ys_held;
                  state_in = ST_YQ;
               end else begin
                  state_in = ST_VQ;
               end
            end
         end
         ST_VQ: begin
            mul_a    = ZW'(iy_ff);
            mul_b    = BW'(M100);
            state_in = ST_VCHK;
         end
         ST_VCHK: begin
            if (act_ff == cda_pkg::ACT_LOAD) begin
               if (!in_ok) begin
                  status_in = cda_pkg::ST_INVALID;
               end else if (32'(iy_ff) > 32'(MAX_YEAR)) begin
                  status_in = cda_pkg::ST_RANGE;
               end else begin
                  held_year_in  = YW'(iy_ff);
                  held_month_in = im_ff;
                  held_day_in   = id_ff;
               end
               state_in = ST_DONE;
            end else begin
               gt_in = held_gt;
               eq_in = held_eq;
               if (!in_ok) begin
                  status_in = cda_pkg::ST_INVALID;
                  state_in  = ST_DONE;
               end else begin
                  c_in     = ys_held;
                  state_in = ST_YQ;
               end
            end
         end
         ST_YQ: begin
            mul_a    = ZW'(c_ff);
            mul_b    = BW'(M100);
            state_in = ST_YF;
         end
         ST_YF: begin
            mul_a    = ZW'(c_ff);
            mul_b    = BW'(cda_pkg::DAYS_PER_YEAR);
            mul_c    = addend;
            state_in = ST_YR;
         end
         ST_YR: begin
            if (search_ff) begin
               // Advance the year while its start still lies at or below the target
               if (f_w <= z_ff) begin
                  fe_in    = f_w;
                  c_in     = c_ff + SYW'(1);
                  state_in = ST_YQ;
               end else begin
                  state_in = ST_CONV;
               end
            end else if (act_ff == cda_pkg::ACT_CMP) begin
               if (!from_input_ff) begin
                  a_in          = f_w;
                  c_in          = ys_input;
                  from_input_in = 1'b1;
                  state_in      = ST_YQ;
               end else begin
                  if (32'(abs_d) > 32'(cda_pkg::DIFF_MAX)) begin
                     diff_in = cda_pkg::DIFF_W'(cda_pkg::DIFF_MAX);
                  end else begin
                     diff_in = cda_pkg::DIFF_W'(abs_d);
                  end
                  state_in = ST_DONE;
               end
            end else if (act_ff == cda_pkg::ACT_ADD) begin
               z_in     = z_add[ZW-1:0];
               state_in = ST_EST;
            end else if (z_sub[ZW]) begin
               status_in = cda_pkg::ST_RANGE;
               state_in  = ST_DONE;
            end else begin
               z_in     = z_sub[ZW-1:0];
               state_in = ST_EST;
            end
         end
         ST_EST: begin
            mul_a    = z_ff;
            mul_b    = BW'(MEST);
            state_in = ST_ERD;
         end
         ST_ERD: begin
            c_in      = mul_p[ZW +: SYW];
            search_in = 1'b1;
            state_in  = ST_YQ;
         end
         ST_CONV: begin
            if (year_ok) begin
               held_year_in  = YW'(yr_new);
               held_month_in = conv_month;
               held_day_in   = conv_day;
            end else begin
               status_in = cda_pkg::ST_RANGE;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and held date
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         held_year_ff  <= YW'(cda_pkg::HELD_YEAR_RESET);
         held_month_ff <= 4'(cda_pkg::HELD_MONTH_RESET);
         held_day_ff   <= 5'(cda_pkg::HELD_DAY_RESET);
      end else begin
         state_ff      <= state_in;
         held_year_ff  <= held_year_in;
         held_month_ff <= held_month_in;
         held_day_ff   <= held_day_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      act_ff        <= act_in;
      iy_ff         <= iy_in;
      im_ff         <= im_in;
      id_ff         <= id_in;
      cnt_ff        <= cnt_in;
      c_ff          <= c_in;
      from_input_ff <= from_input_in;
      search_ff     <= search_in;
      a_ff          <= a_in;
      z_ff          <= z_in;
      fe_ff         <= fe_in;
      gt_ff         <= gt_in;
      eq_ff         <= eq_in;
      diff_ff       <= diff_in;
      status_ff     <= status_in;
   end

   assign cmd_ready     = (state_ff == ST_IDLE);
   assign done          = (state_ff == ST_DONE);
   assign date_year     = held_year_ff[cda_pkg::YEAR_W-1:0];
   assign date_month    = held_month_ff;
   assign date_day      = held_day_ff;
   assign result.gt     = gt_ff;
   assign result.eq     = eq_ff;
   assign result.diff   = diff_ff;
   assign result.status = status_ff;

endmodule
